[rtl/assert_macros.svh]
// Assertion helper macros shared by the RTL of the biquad cascade.
// Depends on nothing; each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

[rtl/bqc_pkg.sv]
// Shared constants and types of the biquad cascade.
// Used by bqc_section and biquad_cascade_iir_filter; depends on nothing.
package bqc_pkg;

	localparam int unsigned MAX_SECTIONS      = 8;
	localparam int unsigned SAMPLE_W          = 16;
	localparam int unsigned COEF_W            = 16;
	localparam int unsigned ACC_W             = 32;
	localparam int unsigned PROD_W            = SAMPLE_W + COEF_W;
	localparam int unsigned OUT_SHIFT         = 15;
	localparam int unsigned COEFS_PER_SECTION = 6;
	localparam int unsigned CIDX_W            = 6;
	localparam int unsigned SEC_W             = $clog2(MAX_SECTIONS);
	localparam int unsigned CNT_W             = 4;
	localparam int unsigned CFG_IDX_W         = 2;
	localparam int unsigned CFG_DATA_W        = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SECTION_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_MODE    = 2'd1;

	// Input commands
	localparam logic CMD_FILTER = 1'b0;
	localparam logic CMD_WRITE  = 1'b1;

	localparam logic [CNT_W-1:0] SECTION_COUNT_RESET = 4'd4;

	// Coefficient slot within a section
	typedef enum logic [2:0] {
		K_B0     = 3'd0,
		K_B1     = 3'd1,
		K_B2     = 3'd2,
		K_UNUSED = 3'd3,
		K_A1     = 3'd4,
		K_A2     = 3'd5
	} coef_k_t;

	// Control from the sequencer to one section cell
	typedef struct packed {
		logic    go;
		logic    en;
		logic    dmode;
		logic    coef_we;
		coef_k_t coef_k;
	} cell_ctl_t;

endpackage

[rtl/biquad_cascade_iir_filter.sv]
// Top level of the biquad cascade: sequencer, configuration registers,
// output buffering and the row of section cells. Depends on bqc_pkg,
// bqc_section and assert_macros.svh.
//
// Usage:
//  - Input channel (in_valid/in_ready): command 0 filters sample_in, command 1
//    writes coef_value to slot coef_index (section*6 + k); writes beyond the
//    last section are dropped. A write completes at its transaction and gives
//    no result.
//  - Output channel (out_valid/out_ready): one sample_out per filter command.
//  - Config channel (cfg_valid/cfg_ready, always ready): index 0 is
//    section_count (0 acts as 1, above 8 acts as 8), index 1 is delay_mode.
//    Write it only while the block is idle.
//  - Timing: a sample walks the cell row one section per cycle, each cell
//    registering it; the result is taken at the last active section, and the
//    next transaction is taken only after that result, so samples never overlap.
//  - A finished result waits in the output register; a second one parks in a
//    hold register. Input stalls while a sample is in flight or it is full.
//  - Reset clears all section states, section_count to 4, delay_mode to 0.
//    Coefficients are undefined until written.
`include "assert_macros.svh"
module biquad_cascade_iir_filter (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    command,
	input  logic signed [bqc_pkg::SAMPLE_W-1:0]     sample_in,
	input  logic        [bqc_pkg::CIDX_W-1:0]       coef_index,
	input  logic signed [bqc_pkg::COEF_W-1:0]       coef_value,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [bqc_pkg::SAMPLE_W-1:0]     sample_out,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic        [bqc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic        [bqc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [bqc_pkg::CNT_W-1:0]  section_count_q;
	logic                       delay_mode_q;
	logic                       busy_q;
	logic                       out_valid_q, pend_valid_q;
	logic signed [bqc_pkg::SAMPLE_W-1:0] out_q, pend_q;
	logic [bqc_pkg::SEC_W-1:0]  last_sec;
	logic                       in_fire, start, wr_fire, done;
	logic signed [bqc_pkg::SAMPLE_W-1:0] cell_x [bqc_pkg::MAX_SECTIONS];
	logic signed [bqc_pkg::SAMPLE_W-1:0] cell_y [bqc_pkg::MAX_SECTIONS];
	logic [bqc_pkg::MAX_SECTIONS-1:0] cell_go_in, cell_go_out;
	bqc_pkg::cell_ctl_t         cell_ctl [bqc_pkg::MAX_SECTIONS];
	logic signed [bqc_pkg::SAMPLE_W-1:0] result;

	// Handshake decode
	assign in_ready  = !busy_q && !pend_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign start     = in_fire && (command == bqc_pkg::CMD_FILTER);
	assign wr_fire   = in_fire && (command == bqc_pkg::CMD_WRITE);
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_count_q <= bqc_pkg::SECTION_COUNT_RESET;
			delay_mode_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bqc_pkg::REG_SECTION_COUNT: section_count_q <= cfg_data;
				bqc_pkg::REG_DELAY_MODE:    delay_mode_q    <= cfg_data[0];
				default:                    ;
			endcase
		end
	end

	// Index of the last active section, with the count clamped to 1..MAX
	always_comb begin
		priority if (section_count_q == '0) begin
			last_sec = '0;
		end else if (section_count_q >= bqc_pkg::CNT_W'(bqc_pkg::MAX_SECTIONS)) begin
			last_sec = bqc_pkg::SEC_W'(bqc_pkg::MAX_SECTIONS - 1);
		end else begin
			last_sec = bqc_pkg::SEC_W'(section_count_q - 1'b1);
		end
	end

	// Row of section cells; each hands its output to the next
	for (genvar gi = 0; gi < bqc_pkg::MAX_SECTIONS; gi++) begin : g_cell
		localparam int unsigned BASE = gi * bqc_pkg::COEFS_PER_SECTION;
		logic                        hit;
		logic [bqc_pkg::CIDX_W-1:0]  rel;

		// indexes below BASE wrap far above the section's slots
		assign rel = coef_index - bqc_pkg::CIDX_W'(BASE);
		assign hit = (rel < bqc_pkg::CIDX_W'(bqc_pkg::COEFS_PER_SECTION));

		if (gi == 0) begin : g_head
			assign cell_x[gi]       = sample_in;
			assign cell_go_in[gi]   = start;
			assign cell_ctl[gi].en  = 1'b1;
		end else begin : g_link
			assign cell_x[gi]       = cell_y[gi-1];
			assign cell_go_in[gi]   = cell_go_out[gi-1];
			assign cell_ctl[gi].en  = (bqc_pkg::SEC_W'(gi) <= last_sec);
		end

		assign cell_ctl[gi].go      = cell_go_in[gi];
		assign cell_ctl[gi].dmode   = delay_mode_q;
		assign cell_ctl[gi].coef_we = wr_fire && hit;
		assign cell_ctl[gi].coef_k  = bqc_pkg::coef_k_t'(rel[2:0]);

		bqc_section u_section (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl[gi]),
			.x_in       (cell_x[gi]),
			.coef_value (coef_value),
			.y_out      (cell_y[gi]),
			.go_out     (cell_go_out[gi])
		);
	end

	// Result tap at the last active section
	assign done   = cell_go_out[last_sec];
	assign result = cell_y[last_sec];

	// Sample in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// Output register plus one hold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (done) begin
				if (out_valid_q && !out_ready) begin
					pend_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (out_valid_q && out_ready) begin
				if (pend_valid_q) begin
					pend_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			if (out_valid_q && !out_ready) begin
				pend_q <= result;
			end else begin
				out_q <= result;
			end
		end else if (out_valid_q && out_ready && pend_valid_q) begin
			out_q <= pend_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

	// Checks
	`ASSERT_ALWAYS(a_one_cell_active, $onehot0(cell_go_out), "more than one cell active")
	`ASSERT_ALWAYS(a_done_while_busy, done |-> busy_q, "result without a sample in flight")
	`ASSERT_ALWAYS(a_pend_behind_out, pend_valid_q |-> out_valid_q, "hold full, output empty")
	`ASSERT_ALWAYS(a_start_sets_busy, start |=> (busy_q || $past(done)), "start did not set busy")

endmodule

[rtl/bqc_section.sv]
// One second-order section cell in transposed direct form II, with its own
// coefficients and delay states. Depends on bqc_pkg.
module bqc_section (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bqc_pkg::cell_ctl_t                     ctl,
	input  logic signed [bqc_pkg::SAMPLE_W-1:0]    x_in,
	input  logic signed [bqc_pkg::COEF_W-1:0]      coef_value,
	output logic signed [bqc_pkg::SAMPLE_W-1:0]    y_out,
	output logic                                   go_out
);

	logic signed [bqc_pkg::COEF_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
	logic signed [bqc_pkg::ACC_W-1:0]  s1_q, s2_q, d1_q, d2_q;
	logic                              go_s1;
	logic signed [bqc_pkg::ACC_W-1:0]  acc_s1, bx1_s1, bx2_s1;
	logic signed [bqc_pkg::PROD_W-1:0] prod_b0, prod_b1, prod_b2, prod_a1, prod_a2;
	logic signed [bqc_pkg::ACC_W-1:0]  acc_next, nf, ns;

	// Coefficient load; the unused slot is dropped
	always_ff @(posedge clk) begin
		if (ctl.coef_we) begin
			unique case (ctl.coef_k)
				bqc_pkg::K_B0:     b0_q <= coef_value;
				bqc_pkg::K_B1:     b1_q <= coef_value;
				bqc_pkg::K_B2:     b2_q <= coef_value;
				bqc_pkg::K_A1:     a1_q <= coef_value;
				bqc_pkg::K_A2:     a2_q <= coef_value;
				bqc_pkg::K_UNUSED: ;
				default:           ;
			endcase
		end
	end

	// Stage 1: feed-forward products and the accumulator
	assign prod_b0  = b0_q * x_in;
	assign prod_b1  = b1_q * x_in;
	assign prod_b2  = b2_q * x_in;
	assign acc_next = bqc_pkg::ACC_W'(prod_b0) + s1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
		end else begin
			go_s1 <= ctl.go & ctl.en;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go && ctl.en) begin
			acc_s1 <= acc_next;
			bx1_s1 <= bqc_pkg::ACC_W'(prod_b1);
			bx2_s1 <= bqc_pkg::ACC_W'(prod_b2);
		end
	end

	// Stage 2: section output (floor shift, wrapped) and feedback terms
	assign y_out   = acc_s1[bqc_pkg::OUT_SHIFT +: bqc_pkg::SAMPLE_W];
	assign go_out  = go_s1;
	assign prod_a1 = a1_q * y_out;
	assign prod_a2 = a2_q * y_out;
	assign nf      = bx1_s1 - bqc_pkg::ACC_W'(prod_a1) + s2_q;
	assign ns      = bx2_s1 - bqc_pkg::ACC_W'(prod_a2);

	// State update; doubled-delay mode routes through the extra registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
			s2_q <= '0;
			d1_q <= '0;
			d2_q <= '0;
		end else if (go_s1) begin
			if (ctl.dmode) begin
				s1_q <= d1_q;
				d1_q <= nf;
				s2_q <= d2_q;
				d2_q <= ns;
			end else begin
				s1_q <= nf;
				s2_q <= ns;
			end
		end
	end

endmodule
